// ===== hw/rtl/tsm_pkg.sv =====
package tsm_pkg;

  typedef enum logic [4:0] {
    OP_PUSHCONST = 5'd0,
    OP_PUSHBOOL  = 5'd1,
    OP_LOAD      = 5'd2,
    OP_STORE     = 5'd3,
    OP_POP       = 5'd4,
    OP_ADD       = 5'd5,
    OP_SUB       = 5'd6,
    OP_MUL       = 5'd7,
    OP_DIV       = 5'd8,
    OP_EQ        = 5'd9,
    OP_NE        = 5'd10,
    OP_LT        = 5'd11,
    OP_LE        = 5'd12,
    OP_GT        = 5'd13,
    OP_GE        = 5'd14,
    OP_NOT       = 5'd15,
    OP_NEG       = 5'd16,
    OP_JUMP      = 5'd17,
    OP_JIF       = 5'd18,
    OP_CLRVARS   = 5'd19,
    OP_HALT      = 5'd20
  } opcode_e;

  typedef enum logic [3:0] {
    ERR_NONE      = 4'd0,
    ERR_UNDERFLOW = 4'd1,
    ERR_INT_EXP   = 4'd2,
    ERR_BOOL_EXP  = 4'd3,
    ERR_EQ_TYPE   = 4'd4,
    ERR_DIV_ZERO  = 4'd5,
    ERR_UNK_VAR   = 4'd6,
    ERR_BAD_SLOT  = 4'd7,
    ERR_JUMP      = 4'd8,
    ERR_UNSUPP    = 4'd9,
    ERR_OVERFLOW  = 4'd10
  } err_e;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_READ  = 3'd1,
    ST_EXEC  = 3'd2,
    ST_WAIT  = 3'd3,
    ST_WRITE = 3'd4,
    ST_OUT   = 3'd5
  } state_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } alu_rsp_t;

endpackage

// ===== hw/rtl/typed_stack_machine_execute_unit.sv =====
// channel   | dir | signals                         | payload
// s_axis    | in  | tvalid tready tdata[39:0]       | req_type[4:0] operand[36:5]
// m_axis    | out | tvalid tready tdata[55:0]       | next_pc[15:0] halted[16] error_code[20:17]
//           |     |                                 | top_valid[21] top_is_bool[22]
//           |     |                                 | top_value[54:23]
// cfg       | in  | cfg_valid_i cfg_ready_o         | program_length[16:0]
// states idle, read, exec, wait, write, out; a new word is accepted only in idle
// add/sub/mul/div wait in wait for the alu's done; divide runs in the radix-2 divider
// after error or halt an item skips exec and wait
// reset clears pc, sp, error, halt and the slot marks; program_length resets to 1
// s_axis_tready low while an item is at work or its word waits on m_axis
module typed_stack_machine_execute_unit #(
  parameter int STACK_DEPTH = 64,
  parameter int VAR_SLOTS   = 64,
  parameter int PC_WIDTH    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // req_type, operand
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // next_pc, halted, error_code, top_valid,
                                      // top_is_bool, top_value
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [16:0] cfg_data_i
);

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int VAW = (VAR_SLOTS > 1) ? $clog2(VAR_SLOTS) : 1;

  tsm_pkg::state_e state_q, state_d;
  logic [16:0]         plen_q;
  logic [PC_WIDTH-1:0] pc_q, pc_d;
  logic [SPW-1:0]      sp_q, sp_d;
  logic [3:0]          err_q, err_d;
  logic                halt_q, halt_d;
  logic [VAR_SLOTS-1:0] def_q, def_d;
  logic [4:0]          op_q;
  logic [31:0]         opd_q;
  logic [32:0]         stk [STACK_DEPTH];
  logic [32:0]         vars [VAR_SLOTS];
  logic [32:0]         r_q, l_q, v_q;
  logic [32:0]         top_q;
  logic                stk_we, var_we;
  logic [SAW-1:0]      stk_wa;
  logic [32:0]         stk_wd;
  logic [SAW-1:0]      ra_r, ra_l, ra_t;
  logic [VAW-1:0]      slot;
  logic                slot_ok;
  logic [32:0]         res_q, res_d;
  logic [55:0]         out_word;
  tsm_pkg::alu_req_t   alu_req;
  tsm_pkg::alu_rsp_t   alu_rsp;
  logic                jok;
  logic                live;
  logic [3:0]          chk;
  logic [3:0]          chk_q;
  logic                lt, eqv;

  function automatic logic alu_req_pending();
    return (op_q == tsm_pkg::OP_ADD) || (op_q == tsm_pkg::OP_SUB)
        || (op_q == tsm_pkg::OP_MUL) || (op_q == tsm_pkg::OP_DIV);
  endfunction

  assign slot_ok = (opd_q < 32'(VAR_SLOTS));
  assign slot    = opd_q[VAW-1:0];
  assign jok     = !opd_q[31] && (opd_q < {15'd0, plen_q})
                   && ((opd_q >> PC_WIDTH) == 32'd0);
  assign live    = (err_q == tsm_pkg::ERR_NONE) && !halt_q;
  assign ra_r    = SAW'(sp_q - SPW'(1));
  assign ra_l    = SAW'(sp_q - SPW'(2));
  assign ra_t    = SAW'(sp_d - SPW'(1));

  assign cfg_ready_o = (state_q == tsm_pkg::ST_IDLE);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= 17'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      plen_q <= cfg_data_i;
    end
  end

  // stack and variables, registered reads
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk[stk_wa] <= stk_wd;
    end
    if (var_we) begin
      vars[slot] <= r_q;
    end
    if (state_q == tsm_pkg::ST_READ) begin
      r_q <= stk[ra_r];
      l_q <= stk[ra_l];
      v_q <= vars[slot];
    end
    if (state_q == tsm_pkg::ST_WRITE) begin
      top_q <= stk_we && (stk_wa == ra_t) ? stk_wd : stk[ra_t];
    end
  end

  tsm_alu u_alu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (alu_req),
    .a_i   (l_q[31:0]),
    .b_i   (r_q[31:0]),
    .rsp_o (alu_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tsm_pkg::ST_IDLE:  if (s_axis_tvalid) state_d = tsm_pkg::ST_READ;
      tsm_pkg::ST_READ:  state_d = live ? tsm_pkg::ST_EXEC : tsm_pkg::ST_WRITE;
      tsm_pkg::ST_EXEC:  state_d = tsm_pkg::ST_WAIT;
      tsm_pkg::ST_WAIT:
        if (alu_rsp.done || !alu_req_pending() || (chk_q != tsm_pkg::ERR_NONE))
          state_d = tsm_pkg::ST_WRITE;
      tsm_pkg::ST_WRITE: state_d = tsm_pkg::ST_OUT;
      tsm_pkg::ST_OUT:   if (m_axis_tready) state_d = tsm_pkg::ST_IDLE;
      default:           state_d = tsm_pkg::ST_IDLE;
    endcase
  end

  // error check and operand class, computed on the read operands
  always_comb begin
    chk = tsm_pkg::ERR_NONE;
    unique case (op_q)
      tsm_pkg::OP_PUSHCONST, tsm_pkg::OP_PUSHBOOL:
        if (sp_q >= SPW'(STACK_DEPTH)) chk = tsm_pkg::ERR_OVERFLOW;
      tsm_pkg::OP_LOAD:
        if (!slot_ok) chk = tsm_pkg::ERR_BAD_SLOT;
        else if (!def_q[slot]) chk = tsm_pkg::ERR_UNK_VAR;
        else if (sp_q >= SPW'(STACK_DEPTH)) chk = tsm_pkg::ERR_OVERFLOW;
      tsm_pkg::OP_STORE:
        if (!slot_ok) chk = tsm_pkg::ERR_BAD_SLOT;
        else if (sp_q == '0) chk = tsm_pkg::ERR_UNDERFLOW;
      tsm_pkg::OP_POP, tsm_pkg::OP_CLRVARS, tsm_pkg::OP_HALT: chk = tsm_pkg::ERR_NONE;
      tsm_pkg::OP_ADD, tsm_pkg::OP_SUB, tsm_pkg::OP_MUL, tsm_pkg::OP_DIV,
      tsm_pkg::OP_LT, tsm_pkg::OP_LE, tsm_pkg::OP_GT, tsm_pkg::OP_GE:
        if (sp_q == '0) chk = tsm_pkg::ERR_UNDERFLOW;
        else if (r_q[32]) chk = tsm_pkg::ERR_INT_EXP;
        else if (sp_q < SPW'(2)) chk = tsm_pkg::ERR_UNDERFLOW;
        else if (l_q[32]) chk = tsm_pkg::ERR_INT_EXP;
        else if (op_q == tsm_pkg::OP_DIV && r_q[31:0] == 32'd0) chk = tsm_pkg::ERR_DIV_ZERO;
      tsm_pkg::OP_EQ, tsm_pkg::OP_NE:
        if (sp_q < SPW'(2)) chk = tsm_pkg::ERR_UNDERFLOW;
        else if (r_q[32] != l_q[32]) chk = tsm_pkg::ERR_EQ_TYPE;
      tsm_pkg::OP_NOT:
        if (sp_q == '0) chk = tsm_pkg::ERR_UNDERFLOW;
        else if (!r_q[32]) chk = tsm_pkg::ERR_BOOL_EXP;
      tsm_pkg::OP_NEG:
        if (sp_q == '0) chk = tsm_pkg::ERR_UNDERFLOW;
        else if (r_q[32]) chk = tsm_pkg::ERR_INT_EXP;
      tsm_pkg::OP_JUMP:
        if (!jok) chk = tsm_pkg::ERR_JUMP;
      tsm_pkg::OP_JIF:
        if (sp_q == '0) chk = tsm_pkg::ERR_UNDERFLOW;
        else if (!r_q[32]) chk = tsm_pkg::ERR_BOOL_EXP;
        else if (r_q[31:0] == 32'd0 && !jok) chk = tsm_pkg::ERR_JUMP;
      default: chk = tsm_pkg::ERR_UNSUPP;
    endcase
  end

  assign lt  = $signed(l_q[31:0]) < $signed(r_q[31:0]);
  assign eqv = (l_q[31:0] == r_q[31:0]);

  // outputs of the sequencer
  always_comb begin
    alu_req.start = 1'b0;
    alu_req.op    = tsm_pkg::ALU_ADD;
    if (state_q == tsm_pkg::ST_EXEC && chk == tsm_pkg::ERR_NONE) begin
      alu_req.start = alu_req_pending();
    end
    unique case (op_q)
      tsm_pkg::OP_SUB: alu_req.op = tsm_pkg::ALU_SUB;
      tsm_pkg::OP_MUL: alu_req.op = tsm_pkg::ALU_MUL;
      tsm_pkg::OP_DIV: alu_req.op = tsm_pkg::ALU_DIV;
      default:         alu_req.op = tsm_pkg::ALU_ADD;
    endcase
  end

  // result word: non-alu ops in exec, the alu result in wait
  always_comb begin
    res_d = res_q;
    if (state_q == tsm_pkg::ST_EXEC) begin
      unique case (op_q)
        tsm_pkg::OP_PUSHBOOL: res_d = {1'b1, 31'd0, (opd_q != 32'd0)};
        tsm_pkg::OP_LOAD:     res_d = v_q;
        tsm_pkg::OP_EQ:       res_d = {1'b1, 31'd0, eqv};
        tsm_pkg::OP_NE:       res_d = {1'b1, 31'd0, !eqv};
        tsm_pkg::OP_LT:       res_d = {1'b1, 31'd0, lt};
        tsm_pkg::OP_LE:       res_d = {1'b1, 31'd0, lt || eqv};
        tsm_pkg::OP_GT:       res_d = {1'b1, 31'd0, !(lt || eqv)};
        tsm_pkg::OP_GE:       res_d = {1'b1, 31'd0, !lt};
        tsm_pkg::OP_NOT:      res_d = {1'b1, 31'd0, (r_q[31:0] == 32'd0)};
        tsm_pkg::OP_NEG:      res_d = {1'b0, 32'd0 - r_q[31:0]};
        default:              res_d = {1'b0, opd_q};
      endcase
    end else if (state_q == tsm_pkg::ST_WAIT && alu_rsp.done) begin
      res_d = {1'b0, alu_rsp.result};
    end
  end

  // commit in write state
  always_comb begin
    pc_d   = pc_q;
    sp_d   = sp_q;
    err_d  = err_q;
    halt_d = halt_q;
    def_d  = def_q;
    stk_we = 1'b0;
    var_we = 1'b0;
    stk_wa = SAW'(sp_q);
    stk_wd = res_q;
    if (state_q == tsm_pkg::ST_WRITE && live) begin
      if (chk_q != tsm_pkg::ERR_NONE) begin
        err_d = chk_q;
      end else begin
        pc_d = pc_q + PC_WIDTH'(1);
        unique case (op_q)
          tsm_pkg::OP_PUSHCONST, tsm_pkg::OP_PUSHBOOL, tsm_pkg::OP_LOAD: begin
            stk_we = 1'b1;
            sp_d   = sp_q + SPW'(1);
          end
          tsm_pkg::OP_STORE: begin
            var_we      = 1'b1;
            def_d[slot] = 1'b1;
            sp_d        = sp_q - SPW'(1);
          end
          tsm_pkg::OP_POP: if (sp_q != '0) sp_d = sp_q - SPW'(1);
          tsm_pkg::OP_NOT, tsm_pkg::OP_NEG: begin
            stk_we = 1'b1;
            stk_wa = ra_r;
          end
          tsm_pkg::OP_JUMP: pc_d = opd_q[PC_WIDTH-1:0];
          tsm_pkg::OP_JIF: begin
            sp_d = sp_q - SPW'(1);
            if (r_q[31:0] == 32'd0) pc_d = opd_q[PC_WIDTH-1:0];
          end
          tsm_pkg::OP_CLRVARS: def_d = '0;
          tsm_pkg::OP_HALT: begin
            halt_d = 1'b1;
            pc_d   = pc_q;
          end
          default: begin
            stk_we = 1'b1;
            stk_wa = ra_l;
            sp_d   = sp_q - SPW'(1);
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsm_pkg::ST_IDLE;
      pc_q    <= '0;
      sp_q    <= '0;
      err_q   <= tsm_pkg::ERR_NONE;
      halt_q  <= 1'b0;
      def_q   <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      sp_q    <= sp_d;
      err_q   <= err_d;
      halt_q  <= halt_d;
      def_q   <= def_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (state_q == tsm_pkg::ST_IDLE && s_axis_tvalid) begin
      op_q  <= s_axis_tdata[4:0];
      opd_q <= s_axis_tdata[36:5];
    end
    if (state_q == tsm_pkg::ST_EXEC) begin
      chk_q <= chk;
    end
  end

  always_comb begin
    out_word[15:0]  = 16'(pc_q);
    out_word[16]    = halt_q;
    out_word[20:17] = err_q;
    out_word[21]    = (sp_q != '0);
    out_word[22]    = (sp_q != '0) ? top_q[32] : 1'b0;
    out_word[54:23] = (sp_q != '0) ? top_q[31:0] : 32'd0;
    out_word[55]    = 1'b0;
  end

  assign s_axis_tready = (state_q == tsm_pkg::ST_IDLE);
  assign m_axis_tvalid = (state_q == tsm_pkg::ST_OUT);
  assign m_axis_tdata  = out_word;

  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(STACK_DEPTH)) else $error("stack pointer out of range");
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != tsm_pkg::ERR_NONE) |=> (err_q == $past(err_q))) else $error("error changed");
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q) else $error("halt cleared");
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != tsm_pkg::ST_WRITE) |=> (pc_q == $past(pc_q))) else $error("pc moved");

endmodule

// ===== hw/rtl/tsm_alu.sv =====
module tsm_alu (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tsm_pkg::alu_req_t req_i,
  input  logic [31:0]      a_i,
  input  logic [31:0]      b_i,
  output tsm_pkg::alu_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic        neg_q, neg_d;
  logic        done_q, done_d;
  logic [31:0] res_q, res_d;
  logic [32:0] trial;
  logic [31:0] ma, mb;

  assign ma = a_i[31] ? (32'd0 - a_i) : a_i;
  assign mb = b_i[31] ? (32'd0 - b_i) : b_i;
  assign trial = {rem_q[31:0], quo_q[31]} - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    res_d  = res_q;
    if (req_i.start) begin
      unique case (req_i.op)
        tsm_pkg::ALU_ADD: begin res_d = a_i + b_i; done_d = 1'b1; end
        tsm_pkg::ALU_SUB: begin res_d = a_i - b_i; done_d = 1'b1; end
        tsm_pkg::ALU_MUL: begin res_d = a_i * b_i; done_d = 1'b1; end
        default: begin
          busy_d = 1'b1;
          cnt_d  = 6'd0;
          quo_d  = ma;
          rem_d  = 33'd0;
          dvs_d  = mb;
          neg_d  = a_i[31] ^ b_i[31];
        end
      endcase
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial;
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        res_d  = neg_q ? (32'd0 - quo_d) : quo_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !req_i.start) else $error("alu started while busy");
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done held");
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == 6'd31) |=> (!busy_q && done_q)) else $error("divide end");

endmodule

// ===== verif/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH     = 64;
  localparam int unsigned SLOTS     = 64;
  localparam int unsigned MAX_CYCLE = 1_500_000;
  localparam int unsigned N_ROWS    = 24;

  typedef struct packed {
    logic [15:0]    pc;
    logic           halted;
    tsm_pkg::err_e  err;
    logic           tv;
    logic           tb;
    logic [31:0]    val;
  } status_t;

  typedef struct {
    tsm_pkg::opcode_e op;
    logic [31:0]      opd;
    bit               typed;
    status_t          res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [16:0] cfg_data = '0;

  // model of the machine
  logic [15:0]   pc_q;
  logic [32:0]   stk_q [DEPTH];
  int unsigned   sp_q;
  logic [32:0]   var_q [SLOTS];
  bit            def_q [SLOTS];
  tsm_pkg::err_e err_q;
  bit            halt_q;
  logic [16:0]   plen_q;

  status_t     status_q [$];
  int unsigned fails = 0, n_items = 0, n_words = 0, cycles = 0, burst_left = 0;
  bit          hold_rx = 1'b0, hold_req = 1'b0, rx_mode = 1'b0;

  typed_stack_machine_execute_unit i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic tsm_pkg::err_e top_check(int unsigned n, int kind);
    for (int unsigned i = 0; i < n; i++) begin
      if (sp_q < i + 1) return tsm_pkg::ERR_UNDERFLOW;
      if (kind == 1 && stk_q[sp_q-1-i][32]) return tsm_pkg::ERR_INT_EXP;
      if (kind == 2 && !stk_q[sp_q-1-i][32]) return tsm_pkg::ERR_BOOL_EXP;
    end
    return tsm_pkg::ERR_NONE;
  endfunction

  function automatic bit jump_ok(logic [31:0] t);
    return !t[31] && t < plen_q && t <= 32'hFFFF;
  endfunction

  function automatic logic [31:0] sdiv(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  // executes one instruction; state changes only when commit is set
  function automatic tsm_pkg::err_e exec_insn(logic [4:0] op, logic [31:0] a, bit commit);
    tsm_pkg::err_e e;
    logic [15:0]   npc;
    logic [32:0]   l, r, res;
    int unsigned   nsp;
    bit            wr, vwr, clr;
    logic          lt;
    e = tsm_pkg::ERR_NONE;
    npc = pc_q + 16'd1;
    nsp = sp_q;
    wr = 0; vwr = 0; clr = 0; res = '0;
    if (err_q != tsm_pkg::ERR_NONE || halt_q) return tsm_pkg::ERR_NONE;
    r = (sp_q > 0) ? stk_q[sp_q-1] : '0;
    l = (sp_q > 1) ? stk_q[sp_q-2] : '0;
    lt = $signed(l[31:0]) < $signed(r[31:0]);
    case (op)
      tsm_pkg::OP_PUSHCONST, tsm_pkg::OP_PUSHBOOL: begin
        if (sp_q >= DEPTH) e = tsm_pkg::ERR_OVERFLOW;
        else begin
          res = (op == tsm_pkg::OP_PUSHBOOL) ? {1'b1, 31'd0, a != 0} : {1'b0, a};
          wr = 1; nsp = sp_q + 1;
        end
      end
      tsm_pkg::OP_LOAD: begin
        if (a >= SLOTS) e = tsm_pkg::ERR_BAD_SLOT;
        else if (!def_q[a]) e = tsm_pkg::ERR_UNK_VAR;
        else if (sp_q >= DEPTH) e = tsm_pkg::ERR_OVERFLOW;
        else begin
          res = var_q[a]; wr = 1; nsp = sp_q + 1;
        end
      end
      tsm_pkg::OP_STORE: begin
        if (a >= SLOTS) e = tsm_pkg::ERR_BAD_SLOT;
        else if (sp_q == 0) e = tsm_pkg::ERR_UNDERFLOW;
        else begin
          vwr = 1; nsp = sp_q - 1;
        end
      end
      tsm_pkg::OP_POP: if (sp_q > 0) nsp = sp_q - 1;
      tsm_pkg::OP_ADD, tsm_pkg::OP_SUB, tsm_pkg::OP_MUL, tsm_pkg::OP_DIV,
      tsm_pkg::OP_LT, tsm_pkg::OP_LE, tsm_pkg::OP_GT, tsm_pkg::OP_GE: begin
        e = top_check(2, 1);
        if (e == tsm_pkg::ERR_NONE && op == tsm_pkg::OP_DIV && r[31:0] == 0)
          e = tsm_pkg::ERR_DIV_ZERO;
        if (e == tsm_pkg::ERR_NONE) begin
          case (op)
            tsm_pkg::OP_ADD: res = {1'b0, l[31:0] + r[31:0]};
            tsm_pkg::OP_SUB: res = {1'b0, l[31:0] - r[31:0]};
            tsm_pkg::OP_MUL: res = {1'b0, l[31:0] * r[31:0]};
            tsm_pkg::OP_DIV: res = {1'b0, sdiv(l[31:0], r[31:0])};
            tsm_pkg::OP_LT:  res = {1'b1, 31'd0, lt};
            tsm_pkg::OP_LE:  res = {1'b1, 31'd0, lt || l[31:0] == r[31:0]};
            tsm_pkg::OP_GT:  res = {1'b1, 31'd0, !lt && l[31:0] != r[31:0]};
            default:         res = {1'b1, 31'd0, !lt};
          endcase
          wr = 1; nsp = sp_q - 1;
        end
      end
      tsm_pkg::OP_EQ, tsm_pkg::OP_NE: begin
        e = top_check(2, 0);
        if (e == tsm_pkg::ERR_NONE && l[32] != r[32]) e = tsm_pkg::ERR_EQ_TYPE;
        if (e == tsm_pkg::ERR_NONE) begin
          res = {1'b1, 31'd0, (l[31:0] == r[31:0]) != (op == tsm_pkg::OP_NE)};
          wr = 1; nsp = sp_q - 1;
        end
      end
      tsm_pkg::OP_NOT, tsm_pkg::OP_NEG: begin
        e = top_check(1, op == tsm_pkg::OP_NOT ? 2 : 1);
        if (e == tsm_pkg::ERR_NONE) begin
          res = (op == tsm_pkg::OP_NOT) ? {1'b1, 31'd0, r[31:0] == 0} : {1'b0, -r[31:0]};
          wr = 1;
        end
      end
      tsm_pkg::OP_JUMP: begin
        if (!jump_ok(a)) e = tsm_pkg::ERR_JUMP;
        else npc = a[15:0];
      end
      tsm_pkg::OP_JIF: begin
        e = top_check(1, 2);
        if (e == tsm_pkg::ERR_NONE && r[31:0] == 0) begin
          if (!jump_ok(a)) e = tsm_pkg::ERR_JUMP;
          else npc = a[15:0];
        end
        if (e == tsm_pkg::ERR_NONE) nsp = sp_q - 1;
      end
      tsm_pkg::OP_CLRVARS: clr = 1;
      tsm_pkg::OP_HALT:    npc = pc_q;
      default:             e = tsm_pkg::ERR_UNSUPP;
    endcase
    if (commit) begin
      if (e != tsm_pkg::ERR_NONE) err_q = e;
      else begin
        if (vwr) begin
          var_q[a] = r; def_q[a] = 1;
        end
        if (clr) foreach (def_q[i]) def_q[i] = 0;
        sp_q = nsp;
        if (wr) stk_q[nsp-1] = res;
        if (op == tsm_pkg::OP_HALT) halt_q = 1;
        pc_q = npc;
      end
    end
    return e;
  endfunction

  function automatic status_t snapshot();
    status_t s;
    s.pc = pc_q;
    s.halted = halt_q;
    s.err = err_q;
    s.tv = sp_q > 0;
    s.tb = (sp_q > 0) ? stk_q[sp_q-1][32] : 1'b0;
    s.val = (sp_q > 0) ? stk_q[sp_q-1][31:0] : '0;
    return s;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'(int'($urandom_range(0, 20)) - 10);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(logic [4:0] op, logic [31:0] a, bit typed, status_t typed_res);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b000, a, op};
    do @(posedge clk_i); while (!s_axis_tready);
    void'(exec_insn(op, a, 1));
    status_q.insert(status_q.size(), typed ? typed_res : snapshot());
    n_items++;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  // picks a well-formed instruction whenever one can be found
  task automatic send_legal();
    logic [4:0]  op;
    logic [31:0] a;
    for (int t = 0; t < 30; t++) begin
      op = 5'($urandom_range(0, 19));
      if (sp_q > 48 && $urandom_range(0, 1)) op = tsm_pkg::OP_POP;
      case (op)
        tsm_pkg::OP_LOAD, tsm_pkg::OP_STORE: a = $urandom_range(0, SLOTS - 1);
        tsm_pkg::OP_JUMP, tsm_pkg::OP_JIF:
          a = $urandom_range(0, plen_q > 65536 ? 65535 : plen_q - 1);
        tsm_pkg::OP_PUSHBOOL: a = $urandom_range(0, 1) ? '0 : $urandom;
        default:              a = rand_value();
      endcase
      if (exec_insn(op, a, 0) == tsm_pkg::ERR_NONE) break;
      op = tsm_pkg::OP_PUSHCONST;
      a = rand_value();
    end
    if (exec_insn(op, a, 0) != tsm_pkg::ERR_NONE) op = tsm_pkg::OP_POP;
    send_word(op, a, 0, '0);
  endtask

  task automatic write_length(logic [16:0] v);
    s_axis_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    plen_q = v;
  endtask

  always @(posedge clk_i) begin
    if (hold_rx) m_axis_tready <= 1'b0;
    else if (rx_mode) m_axis_tready <= $urandom_range(0, 2) == 0;
    else m_axis_tready <= 1'b1;
    if (cycles % 97 == 0) rx_mode <= $urandom_range(0, 1);
  end

  initial begin
    wait (hold_req);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  always @(posedge clk_i) begin
    status_t     want;
    logic [55:0] d;
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      d = m_axis_tdata;
      n_words++;
      if (status_q.size() == 0) begin
        $error("word with nothing expected: %h", d);
        fails++;
      end else begin
        want = status_q.pop_front();
        if (d[15:0] != want.pc) begin
          $error("next_pc exp %0d got %0d", want.pc, d[15:0]); fails++;
        end
        if (d[16] != want.halted) begin
          $error("halted exp %0b got %0b", want.halted, d[16]); fails++;
        end
        if (d[20:17] != want.err) begin
          $error("error_code exp %0d got %0d", want.err, d[20:17]); fails++;
        end
        if (d[21] != want.tv) begin
          $error("top_valid exp %0b got %0b", want.tv, d[21]); fails++;
        end
        if (d[22] != want.tb) begin
          $error("top_is_bool exp %0b got %0b", want.tb, d[22]); fails++;
        end
        if (d[54:23] != want.val) begin
          $error("top_value exp %h got %h", want.val, d[54:23]); fails++;
        end
      end
    end
  end

  initial begin
    wait (cycles >= MAX_CYCLE);
    $display("status: fail");
    $finish;
  end

  row_t rows [N_ROWS] = '{
    '{tsm_pkg::OP_POP,       32'h0000_0000, 1,
      '{16'd1, 1'b0, tsm_pkg::ERR_NONE, 1'b0, 1'b0, 32'h0}},
    '{tsm_pkg::OP_PUSHCONST, 32'h8000_0000, 1,
      '{16'd2, 1'b0, tsm_pkg::ERR_NONE, 1'b1, 1'b0, 32'h8000_0000}},
    '{tsm_pkg::OP_PUSHCONST, 32'hFFFF_FFFF, 1,
      '{16'd3, 1'b0, tsm_pkg::ERR_NONE, 1'b1, 1'b0, 32'hFFFF_FFFF}},
    '{tsm_pkg::OP_DIV,       32'h0000_0000, 1,
      '{16'd4, 1'b0, tsm_pkg::ERR_NONE, 1'b1, 1'b0, 32'h8000_0000}},
    '{tsm_pkg::OP_NEG,       32'h0000_0000, 1,
      '{16'd5, 1'b0, tsm_pkg::ERR_NONE, 1'b1, 1'b0, 32'h8000_0000}},
    '{tsm_pkg::OP_PUSHCONST, 32'h7FFF_FFFF, 1,
      '{16'd6, 1'b0, tsm_pkg::ERR_NONE, 1'b1, 1'b0, 32'h7FFF_FFFF}},
    '{tsm_pkg::OP_ADD,       32'h0000_0000, 1,
      '{16'd7, 1'b0, tsm_pkg::ERR_NONE, 1'b1, 1'b0, 32'hFFFF_FFFF}},
    '{tsm_pkg::OP_STORE,     32'd63,        1,
      '{16'd8, 1'b0, tsm_pkg::ERR_NONE, 1'b0, 1'b0, 32'h0}},
    '{tsm_pkg::OP_LOAD,      32'd63,        1,
      '{16'd9, 1'b0, tsm_pkg::ERR_NONE, 1'b1, 1'b0, 32'hFFFF_FFFF}},
    '{tsm_pkg::OP_PUSHCONST, 32'd2,         0, '0},
    '{tsm_pkg::OP_MUL,       32'h0000_0000, 0, '0},
    '{tsm_pkg::OP_PUSHCONST, 32'h7FFF_FFFF, 0, '0},
    '{tsm_pkg::OP_SUB,       32'h0000_0000, 0, '0},
    '{tsm_pkg::OP_PUSHCONST, 32'd5,         0, '0},
    '{tsm_pkg::OP_GE,        32'h0000_0000, 0, '0},
    '{tsm_pkg::OP_NOT,       32'h0000_0000, 0, '0},
    '{tsm_pkg::OP_PUSHBOOL,  32'h8000_0000, 0, '0},
    '{tsm_pkg::OP_EQ,        32'h0000_0000, 0, '0},
    '{tsm_pkg::OP_PUSHBOOL,  32'h0000_0000, 0, '0},
    '{tsm_pkg::OP_NE,        32'h0000_0000, 0, '0},
    '{tsm_pkg::OP_JIF,       32'h0000_0000, 0, '0},
    '{tsm_pkg::OP_JUMP,      32'h0000_0000, 1,
      '{16'd0, 1'b0, tsm_pkg::ERR_NONE, 1'b0, 1'b0, 32'h0}},
    '{tsm_pkg::OP_CLRVARS,   32'hFFFF_FFFF, 1,
      '{16'd1, 1'b0, tsm_pkg::ERR_NONE, 1'b0, 1'b0, 32'h0}},
    '{tsm_pkg::OP_PUSHCONST, 32'h0000_0001, 0, '0}
  };

  initial begin
    int unsigned tail;
    pc_q = '0; sp_q = 0; err_q = tsm_pkg::ERR_NONE; halt_q = 0; plen_q = 17'd1;
    foreach (def_q[i]) def_q[i] = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send_word(rows[i].op, rows[i].opd, rows[i].typed, rows[i].res);
    write_length(17'h10000);
    repeat (350) send_legal();
    write_length(17'd1);
    repeat (200) send_legal();
    write_length(17'($urandom_range(2, 300)));
    hold_req = 1'b1;
    repeat (350) send_legal();
    write_length(17'($urandom_range(2, 65535)));
    repeat (250) send_legal();
    // random words until the machine faults or halts, then a few ignored ones
    tail = 0;
    while (tail < 20) begin
      if (err_q != tsm_pkg::ERR_NONE || halt_q) tail++;
      send_word(5'($urandom), $urandom_range(0, 1) ? $urandom : $urandom_range(0, 70), 0, '0);
    end
    s_axis_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("%0d instructions sent, %0d words checked, %0d mismatches", n_items, n_words,
             fails);
    $display("run ended with error code %0d, halted %0b", err_q, halt_q);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
